// ===== sv/rrh_pkg.sv =====
// ----------------------------------------------------------------------------
// rrh_pkg: shared types and constants of the RK4 resonant high-pass core
// Controller command and status types, input clamp limits, and the
// fixed-point constants of the cutoff and resonance paths.
// ----------------------------------------------------------------------------
package rrh_pkg;

  // Datapath micro-operations, one per cycle
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_PREP,
    OP_DIVQ_START,
    OP_DIVQ_TAKE,
    OP_MULY_START,
    OP_MULY_TAKE,
    OP_MULT_START,
    OP_MULT_TAKE,
    OP_SUM1,
    OP_SUM2,
    OP_SUM3,
    OP_D6V_START,
    OP_D6V_TAKE,
    OP_D6Y_START,
    OP_D6Y_TAKE,
    OP_OUT
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [1:0] stage;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic mul_done;
    logic out_full;
  } status_t;

  // Input clamp limits
  localparam logic [15:0] FC_MIN = 16'd1;
  localparam logic [15:0] FC_MAX = 16'd16000;
  localparam logic [15:0] Q_MIN  = 16'd153;
  localparam logic [15:0] Q_MAX  = 16'd25600;

  // w0*dt path: (cutoff * scale) >> 4 in Q3.28, capped just under 8.0
  localparam int          W_SHIFT   = 4;
  localparam logic [30:0] W_MAX     = 31'h7FFF_FFFF;
  localparam int          MUL_SHIFT = 28;

  // Q is Q8.8
  localparam int          QFRAC   = 8;
  localparam logic [15:0] DIV_SIX = 16'd6;

  // Configuration space
  localparam int          ADDR_BITS     = 3;
  localparam logic        REG_IDX_SCALE = 1'b0;
  localparam logic [31:0] SCALE_RST     = 32'd562204;

endpackage

// ===== sv/rk4_resonant_highpass_core.sv =====
// ----------------------------------------------------------------------------
// rk4_resonant_highpass_core: resonant second-order high-pass, RK4 step
// Each sample takes six divides on the 8-bit-per-cycle divider and eight
//   w0*dt multiplies in series before out_valid_o rises. in_ready_o is
//   high only while idle, so a new sample waits until the last result is
//   in the output register; a held result stalls the next.
// Reset: asynchronous, active low; clears history, state, scale to 48 kHz.
// ----------------------------------------------------------------------------
module rk4_resonant_highpass_core #(
  parameter int SAMPLE_BITS = 24,
  parameter int STATE_BITS  = 48
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Input channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0] sample_in_i,
  input  logic [15:0]                   cutoff_hz_i,
  input  logic [15:0]                   q_factor_i,
  // Output channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [SAMPLE_BITS-1:0] sample_out_o,
  // Configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rrh_pkg::ADDR_BITS-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  logic [31:0]      scale_q;
  rrh_pkg::cmd_t    cmd;
  rrh_pkg::status_t status;

  // Scale register write on the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= rrh_pkg::SCALE_RST;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[2] == rrh_pkg::REG_IDX_SCALE)) begin
      scale_q <= pwdata;
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == rrh_pkg::REG_IDX_SCALE) ? scale_q : 32'b0;

  rrh_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  rrh_datapath #(
    .X(SAMPLE_BITS),
    .S(STATE_BITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .scale_i      (scale_q),
    .sample_in_i  (sample_in_i),
    .cutoff_hz_i  (cutoff_hz_i),
    .q_factor_i   (q_factor_i),
    .out_ready_i  (out_ready_i),
    .out_valid_o  (out_valid_o),
    .sample_out_o (sample_out_o)
  );

endmodule

// ===== sv/rrh_div.sv =====
// ----------------------------------------------------------------------------
// rrh_div: iterative unsigned divider
// Restoring division, eight quotient bits per cycle. Divisor up to 16 bits.
// done_o pulses for one cycle once quotient_o is valid; it then holds.
// ----------------------------------------------------------------------------
module rrh_div #(
  parameter int DW = 56
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [15:0]   divisor_i,
  output logic          done_o,
  output logic [DW-1:0] quotient_o
);

  localparam int PW  = ((DW + 7) / 8) * 8;
  localparam int NST = PW / 8;
  localparam int CW  = $clog2(NST + 1);

  logic [PW-1:0] qr_q, qr_d;
  logic [15:0]   rem_q, rem_d;
  logic [15:0]   dvs_q;
  logic [CW-1:0] cnt_q;
  logic          done_q;

  // Eight compare-subtract steps per cycle
  always_comb begin
    logic [16:0] r;
    logic [7:0]  qb;
    r  = {1'b0, rem_q};
    qb = '0;
    for (int i = 0; i < 8; i++) begin
      r = {r[15:0], qr_q[PW-1-i]};
      if (r >= {1'b0, dvs_q}) begin
        r         = r - {1'b0, dvs_q};
        qb[7-i]   = 1'b1;
      end
    end
    rem_d = r[15:0];
    qr_d  = {qr_q[PW-9:0], qb};
  end

  // Step counter and done pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= !start_i && (cnt_q == CW'(1));
      if (start_i) begin
        cnt_q <= CW'(NST);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

  // Dividend/quotient shift register and partial remainder
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      qr_q  <= PW'(dividend_i);
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (cnt_q != '0) begin
      qr_q  <= qr_d;
      rem_q <= rem_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = qr_q[DW-1:0];

endmodule

// ===== sv/rrh_mulw.sv =====
// ----------------------------------------------------------------------------
// rrh_mulw: signed state value times w0*dt
// Sign-magnitude multiply by an unsigned Q3.28 factor in two 32x31 partial
// products, then truncation toward zero and saturation to the state range.
// Result registered in the sum phase and flagged by a done pulse.
// ----------------------------------------------------------------------------
module rrh_mulw #(
  parameter int S = 48
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic signed [S-1:0] operand_i,
  input  logic [30:0]         w_i,
  output logic                done_o,
  output logic signed [S-1:0] result_o
);

  localparam logic [S-1:0] SMAX = {1'b0, {(S-1){1'b1}}};
  localparam int MUL_SHIFT_L = rrh_pkg::MUL_SHIFT;

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_LO   = 4'b0010,
    PH_HI   = 4'b0100,
    PH_SUM  = 4'b1000
  } phase_e;

  logic [63:0]         mag_q;
  logic                neg_q;
  logic [62:0]         lo_q, hi_q, pp_d;
  phase_e              ph_q;
  logic                done_q;
  logic signed [S-1:0] res_q, res_d;
  logic [S-1:0]        mag_in;

  assign mag_in = operand_i[S-1] ? (~operand_i + 1'b1) : operand_i;

  // Shared partial product: low half first, then high half
  assign pp_d = (ph_q == PH_LO) ? ({31'b0, mag_q[31:0]} * {32'b0, w_i})
                                : ({31'b0, mag_q[63:32]} * {32'b0, w_i});

  // Recombine, drop 28 fraction bits, saturate, restore sign
  always_comb begin
    logic [94:0] sum;
    logic [66:0] r;
    logic [S-1:0] cap;
    sum = {hi_q, 32'b0} + {32'b0, lo_q};
    r   = sum[94:MUL_SHIFT_L];
    cap = (r > 67'(SMAX)) ? SMAX : r[S-1:0];
    res_d = neg_q ? -$signed(cap) : $signed(cap);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= PH_IDLE;
      done_q <= 1'b0;
    end else begin
      done_q <= (ph_q == PH_SUM);
      case (ph_q)
        PH_IDLE: ph_q <= start_i ? PH_LO : PH_IDLE;
        PH_LO:   ph_q <= PH_HI;
        PH_HI:   ph_q <= PH_SUM;
        default: ph_q <= PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mag_q <= 64'(mag_in);
      neg_q <= operand_i[S-1];
    end
    if (ph_q == PH_LO) lo_q <= pp_d;
    if (ph_q == PH_HI) hi_q <= pp_d;
    if (ph_q == PH_SUM) res_q <= res_d;
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

// ===== sv/rrh_datapath.sv =====
// ----------------------------------------------------------------------------
// rrh_datapath: state, operand registers and arithmetic of the RK4 step
// Executes one micro-operation per cycle as commanded by the controller.
// Holds the filter state, the four stage accelerations and the output
// register, and owns the shared divider and w0*dt multiplier.
// ----------------------------------------------------------------------------
module rrh_datapath #(
  parameter int X = 24,
  parameter int S = 48
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rrh_pkg::cmd_t       cmd_i,
  output rrh_pkg::status_t    status_o,
  input  logic [31:0]         scale_i,
  input  logic signed [X-1:0] sample_in_i,
  input  logic [15:0]         cutoff_hz_i,
  input  logic [15:0]         q_factor_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic signed [X-1:0] sample_out_o
);

  localparam int SHIFT_IN = S - 8 - (X - 1);
  localparam int KABS     = (SHIFT_IN >= 0) ? SHIFT_IN : -SHIFT_IN;
  localparam int DW       = S + rrh_pkg::QFRAC;
  localparam int DWIDE    = S + X + 2 + KABS;
  localparam int OWIDE    = S + X + KABS + 1;

  localparam logic signed [S-1:0] SMAX = {1'b0, {(S-1){1'b1}}};
  localparam logic signed [S-1:0] SMIN = {1'b1, {(S-1){1'b0}}};
  localparam logic signed [DWIDE-1:0] DSMAX = {{(DWIDE-S+1){1'b0}}, {(S-1){1'b1}}};
  localparam logic signed [DWIDE-1:0] DSMIN = {{(DWIDE-S+1){1'b1}}, {(S-1){1'b0}}};
  localparam logic signed [OWIDE-1:0] OXMAX = {{(OWIDE-X+1){1'b0}}, {(X-1){1'b1}}};
  localparam logic signed [OWIDE-1:0] OXMIN = {{(OWIDE-X+1){1'b1}}, {(X-1){1'b0}}};

  // Saturating add in the state range
  function automatic logic signed [S-1:0] sat_add(input logic signed [S-1:0] a,
                                                  input logic signed [S-1:0] b);
    logic signed [S:0] s;
    s = {a[S-1], a} + {b[S-1], b};
    if (s[S] != s[S-1]) sat_add = s[S] ? SMIN : SMAX;
    else sat_add = s[S-1:0];
  endfunction

  function automatic logic [S-1:0] mag(input logic signed [S-1:0] a);
    mag = a[S-1] ? (~a + 1'b1) : a;
  endfunction

  function automatic logic signed [S-1:0] apply_sign(input logic [S-1:0] m,
                                                     input logic neg);
    apply_sign = neg ? -$signed(m) : $signed(m);
  endfunction

  // Filter state (reset to zero)
  logic signed [X-1:0] p0_q, p1_q;
  logic signed [S-1:0] y_q, v_q;
  logic                out_valid_q;

  // Per-item operands
  logic signed [S-1:0] d_q, yh_q, yv_q, ys_q, vs_q, t_q, sv_q, sy_q;
  logic signed [S-1:0] a_q [4];
  logic [30:0]         w_q;
  logic [15:0]         qv_q;
  logic signed [X-1:0] out_q;

  // Next values
  logic signed [S-1:0] d_d, ys_d, vs_d, capq, quo_s, out_neg;
  logic [30:0]         w_d;
  logic [15:0]         qv_d, fcc;
  logic signed [X-1:0] out_d;

  // Shared units
  logic                div_start, div_done, mul_start, mul_done;
  logic [DW-1:0]       dividend, quotient;
  logic [15:0]         divisor;
  logic signed [S-1:0] mul_op, mres;

  // Input conditioning: clamps, w0*dt, second difference of the input
  always_comb begin
    logic [47:0]             wprod;
    logic [47:0]             wsh;
    logic signed [X+1:0]     xe, p0e, p1e, diff;
    logic signed [DWIDE-1:0] dwide, dsh;
    if (cutoff_hz_i < rrh_pkg::FC_MIN) fcc = rrh_pkg::FC_MIN;
    else if (cutoff_hz_i > rrh_pkg::FC_MAX) fcc = rrh_pkg::FC_MAX;
    else fcc = cutoff_hz_i;
    if (q_factor_i < rrh_pkg::Q_MIN) qv_d = rrh_pkg::Q_MIN;
    else if (q_factor_i > rrh_pkg::Q_MAX) qv_d = rrh_pkg::Q_MAX;
    else qv_d = q_factor_i;
    wprod = {32'b0, fcc} * {16'b0, scale_i};
    wsh   = wprod >> rrh_pkg::W_SHIFT;
    w_d   = (wsh > 48'(rrh_pkg::W_MAX)) ? rrh_pkg::W_MAX : wsh[30:0];
    xe    = {{2{sample_in_i[X-1]}}, sample_in_i};
    p0e   = {{2{p0_q[X-1]}}, p0_q};
    p1e   = {{2{p1_q[X-1]}}, p1_q};
    diff  = xe - (p0e <<< 1) + p1e;
    dwide = {{(DWIDE-X-2){diff[X+1]}}, diff};
    dsh   = (SHIFT_IN >= 0) ? (dwide >>> KABS) : (dwide <<< KABS);
    if (dsh > DSMAX) d_d = SMAX;
    else if (dsh < DSMIN) d_d = SMIN;
    else d_d = dsh[S-1:0];
  end

  // Stage operands for the acceleration evaluation
  always_comb begin
    case (cmd_i.stage)
      2'd0: begin
        ys_d = y_q;
        vs_d = v_q;
      end
      2'd1: begin
        ys_d = yh_q;
        vs_d = sat_add(v_q, a_q[0] >>> 1);
      end
      2'd2: begin
        ys_d = sat_add(yh_q, a_q[0] >>> 2);
        vs_d = sat_add(v_q, a_q[1] >>> 1);
      end
      default: begin
        ys_d = sat_add(yv_q, a_q[1] >>> 1);
        vs_d = sat_add(v_q, a_q[2]);
      end
    endcase
  end

  // Divider operand select: V/Q in Q8.8, or a sum over six
  always_comb begin
    div_start = 1'b0;
    dividend  = '0;
    divisor   = rrh_pkg::DIV_SIX;
    case (cmd_i.op)
      rrh_pkg::OP_DIVQ_START: begin
        div_start = 1'b1;
        dividend  = {mag(vs_q), {rrh_pkg::QFRAC{1'b0}}};
        divisor   = qv_q;
      end
      rrh_pkg::OP_D6V_START: begin
        div_start = 1'b1;
        dividend  = {{rrh_pkg::QFRAC{1'b0}}, mag(sv_q)};
      end
      rrh_pkg::OP_D6Y_START: begin
        div_start = 1'b1;
        dividend  = {{rrh_pkg::QFRAC{1'b0}}, mag(sy_q)};
      end
      default: ;
    endcase
  end

  assign capq      = (quotient > DW'(SMAX)) ? SMAX : quotient[S-1:0];
  assign quo_s     = quotient[S-1:0];
  assign mul_start = (cmd_i.op == rrh_pkg::OP_MULY_START) ||
                     (cmd_i.op == rrh_pkg::OP_MULT_START);
  assign mul_op    = (cmd_i.op == rrh_pkg::OP_MULY_START) ? ys_q : t_q;
  assign out_neg   = -mres;

  // Output conversion to the sample format with saturation
  always_comb begin
    logic signed [OWIDE-1:0] ow, osh;
    ow  = {{(OWIDE-S){y_q[S-1]}}, y_q};
    osh = (SHIFT_IN >= 0) ? (ow <<< KABS) : (ow >>> KABS);
    if (osh > OXMAX) out_d = OXMAX[X-1:0];
    else if (osh < OXMIN) out_d = OXMIN[X-1:0];
    else out_d = osh[X-1:0];
  end

  rrh_div #(
    .DW(DW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  rrh_mulw #(
    .S(S)
  ) u_mulw (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (mul_start),
    .operand_i (mul_op),
    .w_i       (w_q),
    .done_o    (mul_done),
    .result_o  (mres)
  );

  // Filter state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p0_q        <= '0;
      p1_q        <= '0;
      y_q         <= '0;
      v_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      case (cmd_i.op)
        rrh_pkg::OP_LOAD: begin
          p0_q <= sample_in_i;
          p1_q <= p0_q;
        end
        rrh_pkg::OP_D6V_TAKE: v_q <= sat_add(v_q, apply_sign(quo_s, sv_q[S-1]));
        rrh_pkg::OP_D6Y_TAKE: y_q <= sat_add(yv_q, apply_sign(quo_s, sy_q[S-1]));
        default: ;
      endcase
      if (cmd_i.op == rrh_pkg::OP_OUT) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // Per-item operand registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      rrh_pkg::OP_LOAD: begin
        d_q  <= d_d;
        w_q  <= w_d;
        qv_q <= qv_d;
        yh_q <= sat_add(y_q, v_q >>> 1);
        yv_q <= sat_add(y_q, v_q);
      end
      rrh_pkg::OP_PREP: begin
        ys_q <= ys_d;
        vs_q <= vs_d;
      end
      rrh_pkg::OP_DIVQ_TAKE: t_q <= apply_sign(capq, vs_q[S-1]);
      rrh_pkg::OP_MULY_TAKE: t_q <= sat_add(t_q, mres);
      rrh_pkg::OP_MULT_TAKE: a_q[cmd_i.stage] <= sat_add(d_q, out_neg);
      rrh_pkg::OP_SUM1: begin
        sv_q <= sat_add(a_q[0], sat_add(a_q[1], a_q[1]));
        sy_q <= sat_add(a_q[0], a_q[1]);
      end
      rrh_pkg::OP_SUM2: begin
        sv_q <= sat_add(sv_q, sat_add(a_q[2], a_q[2]));
        sy_q <= sat_add(sy_q, a_q[2]);
      end
      rrh_pkg::OP_SUM3: sv_q <= sat_add(sv_q, a_q[3]);
      rrh_pkg::OP_OUT:  out_q <= out_d;
      default: ;
    endcase
  end

  assign status_o.div_done = div_done;
  assign status_o.mul_done = mul_done;
  assign status_o.out_full = out_valid_q && !out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign sample_out_o      = out_q;

endmodule

// ===== sv/rrh_ctrl.sv =====
// ----------------------------------------------------------------------------
// rrh_ctrl: sequencer of the RK4 step
// Walks the four acceleration evaluations (V/Q divide, two w0*dt
// multiplies each), the weighted sums, the two divides by six and the
// output write: one datapath operation per cycle outside the wait states.
// ----------------------------------------------------------------------------
module rrh_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  rrh_pkg::status_t status_i,
  output rrh_pkg::cmd_t    cmd_o
);

  typedef enum logic [15:0] {
    ST_IDLE = 16'h0001,
    ST_PREP = 16'h0002,
    ST_DIVS = 16'h0004,
    ST_DIVW = 16'h0008,
    ST_MYS  = 16'h0010,
    ST_MYW  = 16'h0020,
    ST_MTS  = 16'h0040,
    ST_MTW  = 16'h0080,
    ST_SUM1 = 16'h0100,
    ST_SUM2 = 16'h0200,
    ST_SUM3 = 16'h0400,
    ST_D6VS = 16'h0800,
    ST_D6VW = 16'h1000,
    ST_D6YS = 16'h2000,
    ST_D6YW = 16'h4000,
    ST_OUT  = 16'h8000
  } state_e;

  state_e     state_q, state_d;
  logic [1:0] stage_q, stage_d;

  // Next state and command
  always_comb begin
    state_d    = state_q;
    stage_d    = stage_q;
    in_ready_o = 1'b0;
    cmd_o.op   = rrh_pkg::OP_NONE;
    cmd_o.stage = stage_q;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = rrh_pkg::OP_LOAD;
          stage_d  = '0;
          state_d  = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd_o.op = rrh_pkg::OP_PREP;
        state_d  = ST_DIVS;
      end
      ST_DIVS: begin
        cmd_o.op = rrh_pkg::OP_DIVQ_START;
        state_d  = ST_DIVW;
      end
      ST_DIVW: begin
        if (status_i.div_done) begin
          cmd_o.op = rrh_pkg::OP_DIVQ_TAKE;
          state_d  = ST_MYS;
        end
      end
      ST_MYS: begin
        cmd_o.op = rrh_pkg::OP_MULY_START;
        state_d  = ST_MYW;
      end
      ST_MYW: begin
        if (status_i.mul_done) begin
          cmd_o.op = rrh_pkg::OP_MULY_TAKE;
          state_d  = ST_MTS;
        end
      end
      ST_MTS: begin
        cmd_o.op = rrh_pkg::OP_MULT_START;
        state_d  = ST_MTW;
      end
      ST_MTW: begin
        if (status_i.mul_done) begin
          cmd_o.op = rrh_pkg::OP_MULT_TAKE;
          if (stage_q == 2'd3) begin
            state_d = ST_SUM1;
          end else begin
            stage_d = stage_q + 2'd1;
            state_d = ST_PREP;
          end
        end
      end
      ST_SUM1: begin
        cmd_o.op = rrh_pkg::OP_SUM1;
        state_d  = ST_SUM2;
      end
      ST_SUM2: begin
        cmd_o.op = rrh_pkg::OP_SUM2;
        state_d  = ST_SUM3;
      end
      ST_SUM3: begin
        cmd_o.op = rrh_pkg::OP_SUM3;
        state_d  = ST_D6VS;
      end
      ST_D6VS: begin
        cmd_o.op = rrh_pkg::OP_D6V_START;
        state_d  = ST_D6VW;
      end
      ST_D6VW: begin
        if (status_i.div_done) begin
          cmd_o.op = rrh_pkg::OP_D6V_TAKE;
          state_d  = ST_D6YS;
        end
      end
      ST_D6YS: begin
        cmd_o.op = rrh_pkg::OP_D6Y_START;
        state_d  = ST_D6YW;
      end
      ST_D6YW: begin
        if (status_i.div_done) begin
          cmd_o.op = rrh_pkg::OP_D6Y_TAKE;
          state_d  = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!status_i.out_full) begin
          cmd_o.op = rrh_pkg::OP_OUT;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      stage_q <= '0;
    end else begin
      state_q <= state_d;
      stage_q <= stage_d;
    end
  end

`ifndef SYNTHESIS
  a_div_done_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_i.div_done |-> (state_q == ST_DIVW || state_q == ST_D6VW ||
                           state_q == ST_D6YW))
    else $error("divider finished while controller not waiting on it");

  a_mul_done_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_i.mul_done |-> (state_q == ST_MYW || state_q == ST_MTW))
    else $error("multiplier finished while controller not waiting on it");

  a_load_then_prep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.op == rrh_pkg::OP_LOAD |=>
      (cmd_o.op == rrh_pkg::OP_PREP && cmd_o.stage == 2'd0))
    else $error("step did not start at the first stage after a load");

  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.op == rrh_pkg::OP_OUT |-> !status_i.out_full)
    else $error("output register overwritten before transfer");
`endif

endmodule

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench of the RK4 resonant high-pass core
// A clocked driver feeds queued samples over the input handshake, a clocked
// monitor compares every output transfer with a bit-true fixed-point
// predictor of the filter. The scale register is rewritten between phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;

  localparam int SB = 24;
  localparam int TB = 48;
  localparam int SFRAC = TB - 8;
  localparam int SHIFT_IN = SFRAC - (SB - 1);
  localparam longint SMAX = (longint'(1) << (TB - 1)) - 1;
  localparam longint SMIN = -SMAX - 1;
  localparam longint XMAX = (longint'(1) << (SB - 1)) - 1;
  localparam longint XMIN = -XMAX - 1;
  localparam int DRAIN = 200;

  typedef struct {
    logic [SB-1:0] smp;
    logic [15:0]   fc;
    logic [15:0]   q;
  } hp_item_t;

  logic clk_i, rst_ni;
  logic in_valid_i, in_ready_o, out_valid_o, out_ready_i;
  logic signed [SB-1:0] sample_in_i, sample_out_o;
  logic [15:0] cutoff_hz_i, q_factor_i;
  logic psel, penable, pwrite, pready;
  logic [rrh_pkg::ADDR_BITS-1:0] paddr;
  logic [31:0] pwdata, prdata;

  hp_item_t       pending_q[$];
  logic [SB-1:0]  expected_q[$];
  int             errors;
  int             accepted;
  bit             in_done;
  bit             calm;
  int             in_gap, out_gap;

  // Predictor state
  logic [31:0] scale;
  longint      hist0, hist1, lvl, slope;

  rk4_resonant_highpass_core #(.SAMPLE_BITS(SB), .STATE_BITS(TB)) i_dut (.*);

  always begin
    clk_i = 1'b1; #4;
    clk_i = 1'b0; #4;
  end

  function automatic longint sat48(longint x);
    if (x > SMAX) return SMAX;
    if (x < SMIN) return SMIN;
    return x;
  endfunction

  // operands stay well inside 64 bits, so a plain sum then clamp is exact
  function automatic longint sadd(longint a, longint b);
    return sat48(a + b);
  endfunction

  function automatic longint cap_mag(logic [63:0] m, bit neg);
    longint r;
    r = (m > 64'(SMAX)) ? SMAX : longint'(m);
    return neg ? -r : r;
  endfunction

  function automatic logic [63:0] mag(longint x);
    return x < 0 ? 64'(-x) : 64'(x);
  endfunction

  // x * w, w in Q3.28, truncated magnitude
  function automatic longint mulw(longint x, logic [63:0] w);
    logic [63:0] m, ph, pl, r;
    m = mag(x);
    ph = (m >> 32) * w;
    pl = (m & 64'hFFFF_FFFF) * w;
    if (ph > (64'd1 << 59)) r = '1;
    else r = (ph << 4) + (pl >> 28);
    return cap_mag(r, x < 0);
  endfunction

  // x / q, q in Q8.8
  function automatic longint divq(longint x, logic [63:0] q);
    logic [63:0] m, quo, rm, r;
    m = mag(x);
    quo = m / q;
    rm = m % q;
    if (quo > (64'(SMAX) >> 8)) r = '1;
    else r = (quo << 8) + (rm << 8) / q;
    return cap_mag(r, x < 0);
  endfunction

  function automatic longint accel(longint d, logic [63:0] w, logic [63:0] q,
                                   longint y, longint v);
    return sadd(d, -mulw(sadd(divq(v, q), mulw(y, w)), w));
  endfunction

  // Advance the filter by one sample and return the saturated output
  function automatic logic [SB-1:0] filter_step(hp_item_t it);
    longint x, d, a1, a2, a3, a4, sv, sy, o, vn;
    logic [63:0] fc, q, w;
    x = longint'($signed(it.smp));
    fc = it.fc;
    q = it.q;
    if (fc < rrh_pkg::FC_MIN) fc = rrh_pkg::FC_MIN;
    if (fc > rrh_pkg::FC_MAX) fc = rrh_pkg::FC_MAX;
    if (q < rrh_pkg::Q_MIN) q = rrh_pkg::Q_MIN;
    if (q > rrh_pkg::Q_MAX) q = rrh_pkg::Q_MAX;
    w = (fc * 64'(scale)) >> rrh_pkg::W_SHIFT;
    if (w > 64'(rrh_pkg::W_MAX)) w = 64'(rrh_pkg::W_MAX);
    d = sat48((x - 2 * hist0 + hist1) >>> SHIFT_IN);
    a1 = accel(d, w, q, lvl, slope);
    a2 = accel(d, w, q, sadd(lvl, slope >>> 1), sadd(slope, a1 >>> 1));
    a3 = accel(d, w, q, sadd(sadd(lvl, slope >>> 1), a1 >>> 2), sadd(slope, a2 >>> 1));
    a4 = accel(d, w, q, sadd(sadd(lvl, slope), a2 >>> 1), sadd(slope, a3));
    sv = sadd(sadd(sadd(a1, sadd(a2, a2)), sadd(a3, a3)), a4);
    sy = sadd(sadd(a1, a2), a3);
    vn = sadd(slope, sv / 6);
    lvl = sadd(sadd(lvl, slope), sy / 6);
    slope = vn;
    hist1 = hist0;
    hist0 = x;
    // level is scaled up into the sample format, saturating
    if (lvl > (XMAX >>> SHIFT_IN)) o = XMAX;
    else if (lvl < (XMIN >>> SHIFT_IN)) o = XMIN;
    else o = lvl <<< SHIFT_IN;
    return o[SB-1:0];
  endfunction

  // Input driver
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_gap <= 0;
    end else if (in_valid_i && !in_done) begin
      // hold until transfer
    end else if (in_gap > 0) begin
      in_valid_i <= 1'b0;
      in_gap <= in_gap - 1;
    end else if (pending_q.size() > 0 && !(psel)) begin
      if (!calm && $urandom_range(0, 9) == 0) begin
        in_valid_i <= 1'b0;
        in_gap <= $urandom_range(0, 10);
      end else begin
        in_valid_i <= 1'b1;
        sample_in_i <= pending_q[0].smp;
        cutoff_hz_i <= pending_q[0].fc;
        q_factor_i <= pending_q[0].q;
        expected_q.push_back(filter_step(pending_q.pop_front()));
      end
    end else begin
      in_valid_i <= 1'b0;
    end
  end

  // Output stall generator
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      out_gap <= 0;
    end else if (out_gap > 0) begin
      out_ready_i <= 1'b0;
      out_gap <= out_gap - 1;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      out_ready_i <= 1'b0;
      out_gap <= $urandom_range(0, 10);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Count accepted input transfers, flag the transfer for the driver
  always @(posedge clk_i) begin
    in_done <= rst_ni && in_valid_i && in_ready_o;
    if (rst_ni && in_valid_i && in_ready_o) accepted <= accepted + 1;
  end

  // Output monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected output %h", $time, sample_out_o);
        errors++;
      end else begin
        if (sample_out_o !== expected_q[0]) begin
          $display("%0t: sample_out expected %h actual %h", $time, expected_q[0],
                   sample_out_o);
          errors++;
        end
        void'(expected_q.pop_front());
      end
    end
  end

  task automatic apb_write(logic [31:0] val);
    @(negedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= {rrh_pkg::REG_IDX_SCALE, 2'b00};
    pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    scale = val;
  endtask

  task automatic add_item(logic [SB-1:0] s, logic [15:0] f, logic [15:0] q);
    hp_item_t it;
    it.smp = s; it.fc = f; it.q = q;
    pending_q.push_back(it);
  endtask

  // Wait until all queued items have been transferred and answered
  task automatic drain();
    wait (pending_q.size() == 0 && !in_valid_i);
    wait (expected_q.size() == 0);
    repeat (DRAIN) @(posedge clk_i);
  endtask

  function automatic logic [15:0] rand_fc();
    case ($urandom_range(0, 5))
      0: return 16'($urandom_range(0, 65535));
      1: return 16'($urandom_range(0, 50));
      default: return 16'($urandom_range(20, 16100));
    endcase
  endfunction

  function automatic logic [15:0] rand_q();
    case ($urandom_range(0, 4))
      0: return 16'($urandom_range(0, 65535));
      1: return 16'($urandom_range(0, 200));
      default: return 16'($urandom_range(153, 3000));
    endcase
  endfunction

  function automatic logic [SB-1:0] rand_smp();
    case ($urandom_range(0, 4))
      0: return $urandom_range(0, 1) ? {1'b0, {(SB-1){1'b1}}} : {1'b1, {(SB-1){1'b0}}};
      1: return SB'($urandom);
      default: return SB'($signed(16'($urandom)) * 64);
    endcase
  endfunction

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++) add_item(rand_smp(), rand_fc(), rand_q());
    drain();
  endtask

  initial begin
    logic [31:0] scales[5];
    errors = 0; accepted = 0; calm = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    sample_in_i = '0; cutoff_hz_i = '0; q_factor_i = '0;
    scale = rrh_pkg::SCALE_RST;
    hist0 = 0; hist1 = 0; lvl = 0; slope = 0;
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: field extremes, clamp edges, full-scale steps
    add_item(24'h7FFFFF, 16'd0, 16'd0);
    add_item(24'h800000, 16'd1, 16'd153);
    add_item(24'h7FFFFF, 16'd16000, 16'd25600);
    add_item(24'h800000, 16'd16001, 16'd25601);
    add_item(24'h000000, 16'hFFFF, 16'hFFFF);
    add_item(24'h7FFFFF, 16'd1000, 16'd152);
    add_item(24'h800000, 16'd1000, 16'd256);
    add_item(24'h7FFFFF, 16'd15999, 16'd154);
    add_item(24'hFFFFFF, 16'd500, 16'd181);
    add_item(24'h000001, 16'd2000, 16'd25599);
    add_item(24'h555555, 16'h5555, 16'hAAAA);
    add_item(24'hAAAAAA, 16'hAAAA, 16'h5555);
    drain();

    // Largest scale drives w into saturation; also every scale bit toggles
    apb_write(32'hFFFF_FFFF);
    for (int i = 0; i < 6; i++)
      add_item(i[0] ? 24'h800000 : 24'h7FFFFF, 16'd16000, 16'd153);
    drain();

    scales[0] = 32'd1;
    scales[1] = 32'd516539;
    scales[2] = $urandom;
    scales[3] = 32'h0800_0000;
    scales[4] = rrh_pkg::SCALE_RST;
    for (int p = 0; p < 5; p++) begin
      apb_write(scales[p]);
      random_phase(300);
    end
    calm = 1;
    random_phase(200);

    if (errors == 0) begin
      $display("rk4_resonant_highpass_core: match");
    end else begin
      $display("rk4_resonant_highpass_core: mismatch");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("rk4_resonant_highpass_core: mismatch");
    $finish;
  end

endmodule
